// ===== hw/rtl/matrix_inverse_3x3_assert.svh =====
// assertion macros for the matrix inverse checker
// needs clk and rst in the scope where a macro is used
`ifndef MATRIX_INVERSE_3X3_ASSERT_SVH
`define MATRIX_INVERSE_3X3_ASSERT_SVH

// same-cycle implication, masked during reset
`define MI3_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mi3 check failed");

// next-cycle implication, masked during reset
`define MI3_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mi3 check failed");

// next-cycle implication, live during reset
`define MI3_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mi3 reset check failed");

`endif

// ===== hw/rtl/mi3_pkg.sv =====
// shared types, constants and helpers for the 3x3 matrix inverse
// no dependencies
package mi3_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SH2F      = 2 * FRAC_BITS;
  localparam int N         = 9;
  localparam int THR_W     = 31;
  localparam int PROD_W    = 64;
  localparam int ADJ_W     = 65;
  localparam int SPLIT     = 32;
  localparam int PP_W      = 65;
  localparam int TERM_W    = 97;
  localparam int DEN_W     = 97;
  localparam int REM_W     = 130;
  localparam int Q_W       = 33;
  localparam int PADDR_W   = 3;

  localparam logic [THR_W-1:0] THR_RESET = 31'd66;
  localparam logic [31:0]      FX_ONE    = 32'(1) << FRAC_BITS;
  localparam logic [N-1:0]     DIAG      = 9'b100010001;

  // register index, taken from the word address bit
  localparam logic REG_THRESH = 1'b0;

  typedef logic [3:0] idx_t;

  // adjugate entry k = m[PA]*m[PB] - m[PC]*m[PD], column-major
  localparam idx_t PA [N] = '{4'd4, 4'd7, 4'd1, 4'd6, 4'd0, 4'd3, 4'd3, 4'd6, 4'd0};
  localparam idx_t PB [N] = '{4'd8, 4'd2, 4'd5, 4'd5, 4'd8, 4'd2, 4'd7, 4'd1, 4'd4};
  localparam idx_t PC [N] = '{4'd7, 4'd1, 4'd4, 4'd3, 4'd6, 4'd0, 4'd6, 4'd0, 4'd3};
  localparam idx_t PD [N] = '{4'd5, 4'd8, 4'd2, 4'd8, 4'd2, 4'd5, 4'd4, 4'd7, 4'd1};

  typedef struct packed {
    logic signed [31:0] in_c0r0;
    logic signed [31:0] in_c0r1;
    logic signed [31:0] in_c0r2;
    logic signed [31:0] in_c1r0;
    logic signed [31:0] in_c1r1;
    logic signed [31:0] in_c1r2;
    logic signed [31:0] in_c2r0;
    logic signed [31:0] in_c2r1;
    logic signed [31:0] in_c2r2;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] out_c0r0;
    logic signed [31:0] out_c0r1;
    logic signed [31:0] out_c0r2;
    logic signed [31:0] out_c1r0;
    logic signed [31:0] out_c1r1;
    logic signed [31:0] out_c1r2;
    logic signed [31:0] out_c2r0;
    logic signed [31:0] out_c2r1;
    logic signed [31:0] out_c2r2;
    logic signed [31:0] determinant;
    logic               singular;
  } out_word_t;

  typedef struct packed {
    logic          sing;
    logic [N-1:0]  qneg;
    logic [31:0]   det;
  } div_tag_t;

  function automatic logic [31:0] sat32(input logic neg, input logic [DEN_W-1:0] mag);
    logic [31:0] res;
    if (neg) begin
      if (mag > DEN_W'(33'h080000000)) res = 32'h80000000;
      else res = 32'(0) - mag[31:0];
    end else begin
      if (mag > DEN_W'(32'h7fffffff)) res = 32'h7fffffff;
      else res = mag[31:0];
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/mi3_if.sv =====
// valid/ready channels for matrix words and result words
// depends on mi3_pkg
interface mi3_in_if;
  import mi3_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mi3_out_if;
  import mi3_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/mi3_div.sv =====
// pipelined restoring divider, nine lanes sharing one divisor, one quotient bit a stage
// depends on mi3_pkg
module mi3_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [mi3_pkg::DEN_W-1:0] den,
  input  logic [mi3_pkg::REM_W-1:0] num [mi3_pkg::N],
  input  mi3_pkg::div_tag_t        tag_in,
  output logic                     out_valid,
  output logic [mi3_pkg::Q_W-1:0]  q [mi3_pkg::N],
  output mi3_pkg::div_tag_t        tag_out
);
  import mi3_pkg::*;

  logic [REM_W-1:0] rem [Q_W][N];
  logic [Q_W-1:0]   quo [Q_W][N];
  logic [DEN_W-1:0] dd  [Q_W];
  div_tag_t         tg  [Q_W];
  logic [Q_W-1:0]   vld;

  logic [REM_W-1:0] rp  [Q_W][N];
  logic [Q_W-1:0]   qp  [Q_W][N];
  logic [DEN_W-1:0] dp  [Q_W];
  div_tag_t         tp  [Q_W];
  logic [REM_W-1:0] dsh [Q_W];
  logic [N-1:0]     ge  [Q_W];
  logic [REM_W-1:0] rn  [Q_W][N];
  logic [Q_W-1:0]   qn  [Q_W][N];

  always_comb begin
    dp[0] = den;
    tp[0] = tag_in;
    for (int k = 0; k < N; k++) begin
      rp[0][k] = num[k];
      qp[0][k] = '0;
    end
    for (int s = 1; s < Q_W; s++) begin
      dp[s] = dd[s-1];
      tp[s] = tg[s-1];
      for (int k = 0; k < N; k++) begin
        rp[s][k] = rem[s-1][k];
        qp[s][k] = quo[s-1][k];
      end
    end
  end

  always_comb begin
    for (int s = 0; s < Q_W; s++) begin
      dsh[s] = REM_W'(dp[s]) << (Q_W - 1 - s);
      for (int k = 0; k < N; k++) begin
        ge[s][k] = rp[s][k] >= dsh[s];
        rn[s][k] = ge[s][k] ? rp[s][k] - dsh[s] : rp[s][k];
        qn[s][k] = qp[s][k] | (Q_W'(ge[s][k]) << (Q_W - 1 - s));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Q_W-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < Q_W; s++) begin
        dd[s] <= dp[s];
        tg[s] <= tp[s];
        for (int k = 0; k < N; k++) begin
          rem[s][k] <= rn[s][k];
          quo[s][k] <= qn[s][k];
        end
      end
    end
  end

  assign out_valid = vld[Q_W-1];
  assign tag_out   = tg[Q_W-1];
  always_comb begin
    for (int k = 0; k < N; k++) q[k] = quo[Q_W-1][k];
  end

endmodule

// ===== hw/rtl/matrix_inverse_3x3.sv =====
// 3x3 fixed-point matrix inverse by adjugate and determinant, one matrix a cycle while the skid word is empty
// a result word passes seven front stages, 33 quotient stages and the output register
// every stage takes a new word each cycle while the skid word is empty
// reset: synchronous, clears all valid bits and loads the threshold with 66
// depends on mi3_pkg, mi3_if and mi3_div
module matrix_inverse_3x3 (
  input  logic                        clk,
  input  logic                        rst,
  mi3_in_if.sink                      mat,
  mi3_out_if.source                   inv,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mi3_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import mi3_pkg::*;

  logic [THR_W-1:0] thr;
  logic             adv;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (psel && penable && pwrite && (paddr[PADDR_W-1] == REG_THRESH)) begin
      thr <= pwdata[THR_W-1:0];
    end
  end
  assign prdata = (paddr[PADDR_W-1] == REG_THRESH) ? {1'b0, thr} : '0;
  assign pready = 1'b1;

  logic signed [31:0] m_in [N];
  assign m_in[0] = mat.data.in_c0r0;
  assign m_in[1] = mat.data.in_c0r1;
  assign m_in[2] = mat.data.in_c0r2;
  assign m_in[3] = mat.data.in_c1r0;
  assign m_in[4] = mat.data.in_c1r1;
  assign m_in[5] = mat.data.in_c1r2;
  assign m_in[6] = mat.data.in_c2r0;
  assign m_in[7] = mat.data.in_c2r1;
  assign m_in[8] = mat.data.in_c2r2;

  assign mat.ready = adv;

  logic [6:0] v;
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[5:0], mat.valid};
    end
  end

  // cofactor products
  logic signed [PROD_W-1:0] pr_ab [N];
  logic signed [PROD_W-1:0] pr_cd [N];
  logic signed [31:0]       e1 [3];
  logic signed [31:0]       e2 [3];
  // adjugate
  logic signed [ADJ_W-1:0]  adj2 [N];
  logic signed [ADJ_W-1:0]  adj3 [N];
  logic signed [ADJ_W-1:0]  adj4 [N];
  logic signed [ADJ_W-1:0]  adj5 [N];
  // determinant partials and sum
  logic signed [PP_W-1:0]   plo [3];
  logic signed [PP_W-1:0]   phi [3];
  logic signed [TERM_W-1:0] term [3];
  logic signed [TERM_W-1:0] det5;
  // magnitudes
  logic [DEN_W-1:0]         dmag6;
  logic                     dneg6;
  logic [63:0]              amag6 [N];
  logic [N-1:0]             aneg6;
  // divider feed
  logic [DEN_W-1:0]         den7;
  logic [REM_W-1:0]         num7 [N];
  div_tag_t                 tag7;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < N; k++) begin
        pr_ab[k] <= m_in[PA[k]] * m_in[PB[k]];
        pr_cd[k] <= m_in[PC[k]] * m_in[PD[k]];
      end
      e1[0] <= m_in[0];
      e1[1] <= m_in[3];
      e1[2] <= m_in[6];

      for (int k = 0; k < N; k++) adj2[k] <= ADJ_W'(pr_ab[k]) - ADJ_W'(pr_cd[k]);
      e2 <= e1;

      for (int j = 0; j < 3; j++) begin
        plo[j] <= e2[j] * $signed({1'b0, adj2[j][SPLIT-1:0]});
        phi[j] <= e2[j] * $signed(adj2[j][ADJ_W-1:SPLIT]);
      end
      adj3 <= adj2;

      for (int j = 0; j < 3; j++) term[j] <= (TERM_W'(phi[j]) <<< SPLIT) + TERM_W'(plo[j]);
      adj4 <= adj3;

      det5 <= term[0] + term[1] + term[2];
      adj5 <= adj4;

      dneg6 <= det5[TERM_W-1];
      dmag6 <= det5[TERM_W-1] ? DEN_W'(-det5) : DEN_W'(det5);
      for (int k = 0; k < N; k++) begin
        aneg6[k] <= adj5[k][ADJ_W-1];
        amag6[k] <= adj5[k][ADJ_W-1] ? 64'(-adj5[k]) : adj5[k][63:0];
      end

      den7      <= dmag6;
      tag7.sing <= (dmag6 == '0) || (dmag6 < (DEN_W'(thr) << SH2F));
      tag7.qneg <= aneg6 ^ {N{dneg6}};
      tag7.det  <= sat32(dneg6, dmag6 >> SH2F);
      for (int k = 0; k < N; k++) num7[k] <= REM_W'(amag6[k]) << SH2F;
    end
  end

  logic             pv;
  logic [Q_W-1:0]   q [N];
  div_tag_t         tq;

  mi3_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (v[6]),
    .den      (den7),
    .num      (num7),
    .tag_in   (tag7),
    .out_valid(pv),
    .q        (q),
    .tag_out  (tq)
  );

  // saturation and identity select
  logic [31:0] res [N];
  out_word_t   fw;
  always_comb begin
    for (int k = 0; k < N; k++) begin
      if (tq.sing) res[k] = DIAG[k] ? FX_ONE : '0;
      else res[k] = sat32(tq.qneg[k], DEN_W'(q[k]));
    end
    fw.out_c0r0    = res[0];
    fw.out_c0r1    = res[1];
    fw.out_c0r2    = res[2];
    fw.out_c1r0    = res[3];
    fw.out_c1r1    = res[4];
    fw.out_c1r2    = res[5];
    fw.out_c2r0    = res[6];
    fw.out_c2r1    = res[7];
    fw.out_c2r2    = res[8];
    fw.determinant = tq.det;
    fw.singular    = tq.sing;
  end

  // output register with skid word
  logic      out_v;
  logic      skid_v;
  out_word_t out_d;
  out_word_t skid_d;

  assign adv = !skid_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!out_v || inv.ready) begin
      out_v  <= skid_v || pv;
      skid_v <= 1'b0;
    end else if (pv && !skid_v) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v || inv.ready) begin
      out_d <= skid_v ? skid_d : fw;
    end else if (!skid_v) begin
      skid_d <= fw;
    end
  end

  assign inv.valid = out_v;
  assign inv.data  = out_d;

endmodule

// ===== hw/rtl/mi3_chk.sv =====
// port-level checks on the result channel of the matrix inverse
// depends on mi3_pkg and matrix_inverse_3x3_assert.svh, bound to matrix_inverse_3x3
`include "matrix_inverse_3x3_assert.svh"

module mi3_chk (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input mi3_pkg::out_word_t out_data
);
  import mi3_pkg::*;

  `MI3_ASSERT_NEXT(a_valid_held, out_valid && !out_ready, out_valid)
  `MI3_ASSERT_NEXT(a_word_held, out_valid && !out_ready, $stable(out_data))
  `MI3_ASSERT_RST(a_reset_empty, rst, !out_valid)
  `MI3_ASSERT_SAME(a_singular_ident, out_valid && out_data.singular, (out_data.out_c0r0 == FX_ONE) && (out_data.out_c1r1 == FX_ONE) && (out_data.out_c2r2 == FX_ONE) && (out_data.out_c0r1 == '0) && (out_data.out_c1r0 == '0) && (out_data.out_c2r0 == '0))

endmodule

bind matrix_inverse_3x3 mi3_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .out_valid(inv.valid),
  .out_ready(inv.ready),
  .out_data (inv.data)
);

// ===== test/matrix_inverse_3x3_tb.sv =====
// self-checking testbench for the 3x3 fixed-point matrix inverse
// drives matrix words, predicts inverse, determinant and singular flag, checks every result
// depends on mi3_pkg, mi3_if and the matrix_inverse_3x3 rtl
`timescale 1ns / 100ps

module matrix_inverse_3x3_tb;
  import mi3_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam logic [PADDR_W-1:0] ADDR_THRESH = PADDR_W'(0);

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  mi3_in_if mat_if ();
  mi3_out_if inv_if ();

  matrix_inverse_3x3 dut (
    .clk(clk), .rst(rst), .mat(mat_if), .inv(inv_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  in_word_t matrix_q [$];
  out_word_t inverse_q [$];
  logic [THR_W-1:0] thresh_shadow;
  int src_idle_pct;
  int snk_idle_pct;
  int errors;
  int words_in;
  int words_out;
  int singular_seen;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] clamp32(input logic neg, input logic [127:0] mag);
    if (neg) return (mag > 128'h80000000) ? 32'h80000000 : 32'(0) - mag[31:0];
    return (mag > 128'h7fffffff) ? 32'h7fffffff : mag[31:0];
  endfunction

  function automatic out_word_t invert(input in_word_t w, input logic [THR_W-1:0] thr);
    logic signed [31:0] m [9];
    logic signed [64:0] cof [9];
    logic signed [127:0] det;
    logic [127:0] dmag, cmag, q, lim;
    logic dneg, sing;
    logic [31:0] o [9];
    out_word_t r;
    m = '{w.in_c0r0, w.in_c0r1, w.in_c0r2, w.in_c1r0, w.in_c1r1, w.in_c1r2,
          w.in_c2r0, w.in_c2r1, w.in_c2r2};
    cof[0] = longint'(m[4]) * m[8] - longint'(m[7]) * m[5];
    cof[3] = longint'(m[6]) * m[5] - longint'(m[3]) * m[8];
    cof[6] = longint'(m[3]) * m[7] - longint'(m[6]) * m[4];
    cof[1] = longint'(m[7]) * m[2] - longint'(m[1]) * m[8];
    cof[4] = longint'(m[0]) * m[8] - longint'(m[6]) * m[2];
    cof[7] = longint'(m[6]) * m[1] - longint'(m[0]) * m[7];
    cof[2] = longint'(m[1]) * m[5] - longint'(m[4]) * m[2];
    cof[5] = longint'(m[3]) * m[2] - longint'(m[0]) * m[5];
    cof[8] = longint'(m[0]) * m[4] - longint'(m[3]) * m[1];
    det = m[0] * cof[0] + m[3] * cof[1] + m[6] * cof[2];
    dneg = det[127];
    dmag = dneg ? -det : det;
    lim = 128'(thr) << (2 * FRAC_BITS);
    sing = (dmag == 0) || (dmag < lim);
    for (int k = 0; k < 9; k++) begin
      if (sing) begin
        o[k] = (k % 4 == 0) ? 32'(1) << FRAC_BITS : 32'd0;
      end else begin
        cmag = cof[k][64] ? 128'(-cof[k]) : 128'(cof[k]);
        q = (cmag << (2 * FRAC_BITS)) / dmag;
        o[k] = (q == 0) ? 32'd0 : clamp32(cof[k][64] ^ dneg, q);
      end
    end
    q = dmag >> (2 * FRAC_BITS);
    r.out_c0r0 = o[0]; r.out_c0r1 = o[1]; r.out_c0r2 = o[2];
    r.out_c1r0 = o[3]; r.out_c1r1 = o[4]; r.out_c1r2 = o[5];
    r.out_c2r0 = o[6]; r.out_c2r1 = o[7]; r.out_c2r2 = o[8];
    r.determinant = (q == 0) ? 32'd0 : clamp32(dneg, q);
    r.singular = sing;
    return r;
  endfunction

  function automatic in_word_t pack_matrix(input logic [31:0] e [9]);
    return {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
  endfunction

  function automatic logic [31:0] pick_entry(input int kind);
    logic [31:0] odd [8];
    odd = '{32'h80000000, 32'h7fffffff, 32'd0, 32'd1, 32'hffffffff, 32'h00010000,
            32'hffff0000, 32'h80000001};
    case (kind)
      0: return $urandom;
      1: return 32'(int'($urandom_range(0, 8 << 16)) - (4 << 16));
      2: return odd[$urandom_range(0, 7)];
      default: return 32'(int'($urandom_range(0, 1 << 14)) - (1 << 13));
    endcase
  endfunction

  function automatic in_word_t random_matrix();
    logic [31:0] e [9];
    int style;
    style = $urandom_range(0, 99);
    for (int k = 0; k < 9; k++) begin
      if (style < 40) e[k] = pick_entry(1);
      else if (style < 60) e[k] = pick_entry(0);
      else if (style < 75) e[k] = pick_entry($urandom_range(0, 3));
      else if (style < 90) begin
        // diagonally dominant, well conditioned
        e[k] = (k % 4 == 0) ? 32'(int'($urandom_range(1 << 16, 16 << 16))
               * ($urandom_range(0, 1) ? 1 : -1)) : pick_entry(3);
      end else e[k] = pick_entry(1);
    end
    // rank deficient: one column repeats another
    if (style >= 90) begin
      e[6] = e[0]; e[7] = e[1]; e[8] = e[2];
    end
    return pack_matrix(e);
  endfunction

  task automatic push_diag(input logic [31:0] a, b, c);
    logic [31:0] e [9];
    e = '{a, 32'd0, 32'd0, 32'd0, b, 32'd0, 32'd0, 32'd0, c};
    matrix_q.push_back(pack_matrix(e));
  endtask

  task automatic push_fill(input logic [31:0] v);
    logic [31:0] e [9];
    foreach (e[k]) e[k] = v;
    matrix_q.push_back(pack_matrix(e));
  endtask

  task automatic write_thresh(input logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_THRESH;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    thresh_shadow = v[THR_W-1:0];
  endtask

  task automatic drain();
    while (matrix_q.size() != 0 || mat_if.valid || inverse_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v, act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      mat_if.valid <= 1'b0;
      mat_if.data <= '0;
    end else begin
      if (mat_if.valid && mat_if.ready) begin
        inverse_q.push_back(invert(mat_if.data, thresh_shadow));
        words_in++;
      end
      if (!mat_if.valid || mat_if.ready) begin
        if (matrix_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          mat_if.data <= matrix_q.pop_front();
          mat_if.valid <= 1'b1;
        end else begin
          mat_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_word_t e, a;
    if (rst) begin
      inv_if.ready <= 1'b0;
    end else begin
      inv_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      if (inv_if.valid && inv_if.ready) begin
        a = inv_if.data;
        words_out++;
        if (inverse_q.size() == 0) begin
          $error("unexpected result word %h", a);
          errors++;
        end else begin
          e = inverse_q.pop_front();
          if (a.singular) singular_seen++;
          check_field("out_c0r0", e.out_c0r0, a.out_c0r0);
          check_field("out_c0r1", e.out_c0r1, a.out_c0r1);
          check_field("out_c0r2", e.out_c0r2, a.out_c0r2);
          check_field("out_c1r0", e.out_c1r0, a.out_c1r0);
          check_field("out_c1r1", e.out_c1r1, a.out_c1r1);
          check_field("out_c1r2", e.out_c1r2, a.out_c1r2);
          check_field("out_c2r0", e.out_c2r0, a.out_c2r0);
          check_field("out_c2r1", e.out_c2r1, a.out_c2r1);
          check_field("out_c2r2", e.out_c2r2, a.out_c2r2);
          check_field("determinant", e.determinant, a.determinant);
          check_field("singular", 32'(e.singular), 32'(a.singular));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((mat_if.valid && mat_if.ready) || (inv_if.valid && inv_if.ready) ||
        (matrix_q.size() == 0 && !mat_if.valid && inverse_q.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("timeout with %0d results outstanding", inverse_q.size());
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [31:0] thr_list [4];
    int src_list [4];
    int snk_list [4];
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    thresh_shadow = THR_RESET;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    errors = 0;
    words_in = 0;
    words_out = 0;
    singular_seen = 0;
    quiet_cycles = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (5) @(posedge clk);

    // directed words at the reset threshold of 66
    write_thresh(32'd66);
    push_fill(32'd0);
    push_diag(32'h10000, 32'h10000, 32'h10000);
    push_diag(32'hffff0000, 32'h20000, 32'h00008000);
    push_diag(66 << 16, 32'h10000, 32'h10000);
    push_diag((66 << 16) - 1, 32'h10000, 32'h10000);
    push_diag(32'hffffffff << 0, 32'd1, 32'd1);
    push_diag(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    push_diag(32'h80000000, 32'h80000000, 32'h80000000);
    push_diag(32'h80000000, 32'h7fffffff, 32'h10000);
    push_diag(32'd1, 32'h10000, 32'h10000);
    push_diag(32'h7fffffff, 32'd1, 32'd1);
    push_fill(32'h80000000);
    push_fill(32'h7fffffff);
    push_fill(32'hffffffff);
    push_fill(32'h10000);
    begin
      logic [31:0] e [9];
      e = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
            32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000};
      matrix_q.push_back(pack_matrix(e));
      e = '{32'h20000, 32'h10000, 32'd0, 32'h10000, 32'h20000, 32'h10000,
            32'd0, 32'h10000, 32'h20000};
      matrix_q.push_back(pack_matrix(e));
      e = '{32'd0, 32'h10000, 32'd0, 32'h10000, 32'd0, 32'd0, 32'd0, 32'd0, 32'h10000};
      matrix_q.push_back(pack_matrix(e));
    end
    drain();

    thr_list = '{32'd0, 32'hffffffff, 32'd66, 32'd0};
    thr_list[3] = $urandom_range(0, 1 << 12);
    src_list = '{0, 81, 0, 34};
    snk_list = '{0, 0, 81, 34};
    for (int p = 0; p < 4; p++) begin
      write_thresh(thr_list[p]);
      src_idle_pct = src_list[p];
      snk_idle_pct = snk_list[p];
      for (int i = 0; i < 400; i++) matrix_q.push_back(random_matrix());
      drain();
    end
    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_thresh(32'd66);
    for (int i = 0; i < 40; i++) matrix_q.push_back(random_matrix());
    drain();

    $display("%0d matrix words in, %0d result words checked, %0d singular",
             words_in, words_out, singular_seen);
    $display("thresholds 0, max, 66 and random; idle and stall phases on both sides");
    if (errors == 0 && inverse_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
